// File: rtl/sha1_pkg.sv
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] state_words_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic [7:0] load_byte;
		logic       start;
		logic       step;
	} sha1_ctl_t;

	localparam int ROUNDS = 80;
	localparam int BLOCK_BITS = 512;
	localparam int COUNT_BITS = 61;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd4;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam state_words_t IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	function automatic word_t round_k(input logic [6:0] rnd);
		word_t k;
		if (rnd < 7'd20) begin
			k = K0;
		end else if (rnd < 7'd40) begin
			k = K1;
		end else if (rnd < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	function automatic word_t round_f(input logic [6:0] rnd, input word_t b, input word_t c,
			input word_t d);
		word_t f;
		if (rnd < 7'd20) begin
			f = d ^ (b & (c ^ d));
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (d & (b | c));
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

// File: rtl/sha1_round.sv
module sha1_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1_pkg::sha1_ctl_t   ctl,
	input  sha1_pkg::state_words_t cv,
	output sha1_pkg::state_words_t work,
	output logic                  round_last
);
	import sha1_pkg::*;

	logic [BLOCK_BITS-1:0] blk_q;
	state_words_t          work_q;
	logic [6:0]            rnd_q;
	word_t                 w_cur;
	word_t                 w_mix;
	word_t                 w_new;
	word_t                 t_sum;

	function automatic word_t blk_word(input logic [BLOCK_BITS-1:0] blk, input int j);
		return blk[BLOCK_BITS-1-32*j -: 32];
	endfunction

	always_comb begin
		w_cur = blk_word(blk_q, 0);
		w_mix = blk_word(blk_q, 13) ^ blk_word(blk_q, 8) ^ blk_word(blk_q, 2) ^ w_cur;
		w_new = {w_mix[30:0], w_mix[31]};
		t_sum = {work_q[0][26:0], work_q[0][31:27]}
			+ round_f(rnd_q, work_q[1], work_q[2], work_q[3])
			+ work_q[4] + round_k(rnd_q) + w_cur;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			blk_q <= {blk_q[BLOCK_BITS-9:0], ctl.load_byte};
		end else if (ctl.step) begin
			blk_q <= {blk_q[BLOCK_BITS-33:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q <= cv;
		end else if (ctl.step) begin
			work_q[4] <= work_q[3];
			work_q[3] <= work_q[2];
			work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
			work_q[1] <= work_q[0];
			work_q[0] <= t_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (ctl.start) begin
			rnd_q <= '0;
		end else if (ctl.step) begin
			rnd_q <= rnd_q + 7'd1;
		end
	end

	assign work = work_q;
	assign round_last = (rnd_q == 7'(ROUNDS - 1));

endmodule

// File: rtl/sha1_message_digest.sv
// SHA-1 hash engine that takes the message one byte per input item and gives the
// 160-bit digest as five 32-bit output items, word 0 first. While no block is full an
// item is taken every cycle; the item that completes a 64-byte block, and an item with
// end_of_message set, hold the input not ready while the single shared round unit runs
// its 80 rounds and then adds into the chaining value for each block. Finishing a
// message shifts one padding or length byte per cycle until the last block is full
// (9 to 72 bytes, compressed in one or two blocks), then presents the five
// digest words, one per accepted output item, and returns to the initial vector.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1_pkg::*;

	state_t                state_q;
	state_t                state_d;
	state_words_t          cv_q;
	state_words_t          work;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [5:0]            fill_q;
	logic [2:0]            idx_q;
	logic                  eom_q;
	logic                  pad_q;
	logic                  mark_q;
	logic                  len_q;
	logic                  fin_q;
	logic                  round_last;
	logic                  in_fire;
	logic                  out_fire;
	logic [63:0]           len_bits;
	logic [2:0]            len_sel;
	logic [7:0]            pad_byte;
	sha1_ctl_t             ctl;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign len_bits = {cnt_q, 3'b000};
	assign len_sel = 3'd7 - fill_q[2:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (byte_valid && fill_q == LAST_POS) begin
						state_d = ST_ROUND;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_POS) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (!pad_q) begin
					state_d = eom_q ? ST_PAD : ST_IDLE;
				end else begin
					state_d = fin_q ? ST_OUT : ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_fire && idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_q && fill_q >= LEN_POS) begin
			pad_byte = len_bits[{len_sel, 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
		ctl.load = (in_fire && byte_valid) || (state_q == ST_PAD);
		ctl.load_byte = (state_q == ST_PAD) ? pad_byte : data_byte;
		ctl.start = (state_d == ST_ROUND) && (state_q != ST_ROUND);
		ctl.step = (state_q == ST_ROUND);
	end

	sha1_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cv        (cv_q),
		.work      (work),
		.round_last(round_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q    <= IV;
			cnt_q   <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
			eom_q   <= 1'b0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				fill_q <= fill_q + 6'd1;
			end
			if (in_fire) begin
				eom_q <= end_of_message;
				if (byte_valid) begin
					cnt_q <= cnt_q + COUNT_BITS'(1);
				end
			end
			if (state_d == ST_PAD) begin
				pad_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				mark_q <= 1'b1;
				if (fill_q == LAST_POS) begin
					if (mark_q && len_q) begin
						fin_q <= 1'b1;
					end else begin
						len_q <= 1'b1;
					end
				end else if (!mark_q) begin
					len_q <= (fill_q < LEN_POS);
				end
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 5; i++) begin
					cv_q[i] <= cv_q[i] + work[i];
				end
			end
			if (out_fire) begin
				if (idx_q == LAST_IDX) begin
					idx_q  <= '0;
					cv_q   <= IV;
					cnt_q  <= '0;
					fill_q <= '0;
					eom_q  <= 1'b0;
					pad_q  <= 1'b0;
					mark_q <= 1'b0;
					len_q  <= 1'b0;
					fin_q  <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	assign digest_word = cv_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == LAST_IDX);

endmodule
